// ===== sv/bur_pkg.sv =====
// Shared types and constants for the bounded undo/redo history block.
package bur_pkg;

  localparam int MAX_DEPTH_DEF = 16;
  localparam int TAG_BITS_DEF  = 16;
  localparam int LIMIT_BITS    = 5;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 5'd16;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_UNDO  = 2'd1,
    OP_REDO  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EXEC,
    ST_TOPS,
    ST_OUT
  } st_e;

  typedef struct packed {
    logic load;
    logic rd;
    logic exec;
  } cmd_t;

endpackage

// ===== sv/bur_ring.sv =====
// Ring storage for one history stack with one write port and a registered read port.
module bur_ring #(
  parameter int DEPTH = bur_pkg::MAX_DEPTH_DEF,
  parameter int TW    = bur_pkg::TAG_BITS_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [TW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [TW-1:0] rdata_o
);

  logic [TW-1:0] mem [DEPTH];
  logic [TW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/bur_ctrl.sv =====
// Sequencer that steps one request through fetch, update, top readback and result.
module bur_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bur_pkg::cmd_t cmd_o
);

  bur_pkg::st_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bur_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bur_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = bur_pkg::ST_FETCH;
      end
      bur_pkg::ST_FETCH: state_d = bur_pkg::ST_EXEC;
      bur_pkg::ST_EXEC:  state_d = bur_pkg::ST_TOPS;
      bur_pkg::ST_TOPS:  state_d = bur_pkg::ST_OUT;
      bur_pkg::ST_OUT: begin
        if (!out_stall_i) state_d = bur_pkg::ST_IDLE;
      end
      default: state_d = bur_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      bur_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      bur_pkg::ST_FETCH: cmd_o.rd = 1'b1;
      bur_pkg::ST_EXEC:  cmd_o.exec = 1'b1;
      bur_pkg::ST_TOPS:  cmd_o.rd = 1'b1;
      bur_pkg::ST_OUT:   out_valid_o = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== sv/bur_dp.sv =====
// Datapath: request latch, depth limit, stack pointers and counts, two ring memories.
module bur_dp #(
  parameter int MAX_DEPTH = bur_pkg::MAX_DEPTH_DEF,
  parameter int TAG_BITS  = bur_pkg::TAG_BITS_DEF,
  localparam int CW = $clog2(MAX_DEPTH + 1),
  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1,
  localparam int LW = (CW > bur_pkg::LIMIT_BITS) ? CW : bur_pkg::LIMIT_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  bur_pkg::cmd_t                  cmd_i,
  input  logic                           cfg_we_i,
  input  logic [bur_pkg::LIMIT_BITS-1:0] cfg_wdata_i,
  input  logic [1:0]                     op_i,
  input  logic                           entry_present_i,
  input  logic [TAG_BITS-1:0]            entry_tag_i,
  output logic                           ok_o,
  output logic [TAG_BITS-1:0]            moved_tag_o,
  output logic                           undo_avail_o,
  output logic                           redo_avail_o,
  output logic [TAG_BITS-1:0]            next_undo_tag_o,
  output logic [TAG_BITS-1:0]            next_redo_tag_o,
  output logic [CW-1:0]                  undo_depth_o,
  output logic [CW-1:0]                  redo_depth_o
);

  function automatic logic [AW-1:0] wrap_idx(input logic [CW:0] s);
    logic [CW:0] r;
    r = (s >= (CW+1)'(MAX_DEPTH)) ? s - (CW+1)'(MAX_DEPTH) : s;
    return r[AW-1:0];
  endfunction

  logic [bur_pkg::LIMIT_BITS-1:0] limit_q;
  bur_pkg::op_e                   op_q;
  logic                           present_q;
  logic [TAG_BITS-1:0]            tag_q;

  logic [AW-1:0] u_old_q, u_old_d, r_old_q, r_old_d;
  logic [CW-1:0] u_cnt_q, u_cnt_d, r_cnt_q, r_cnt_d;
  logic          ok_q, ok_d;
  logic [TAG_BITS-1:0] moved_q, moved_d;

  logic [LW-1:0] lim_ext, eff_lim;
  logic [AW-1:0] u_top, r_top, u_tail, r_tail, u_inc, r_inc;
  logic          u_trim, r_trim;
  logic          u_we, r_we;
  logic [TAG_BITS-1:0] u_wdata, r_wdata, u_rdata, r_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= bur_pkg::LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q      <= bur_pkg::op_e'(op_i);
      present_q <= entry_present_i;
      tag_q     <= entry_tag_i;
    end
  end

  assign lim_ext = LW'(limit_q);
  assign eff_lim = (lim_ext == '0) ? LW'(1) :
                   (lim_ext > LW'(MAX_DEPTH)) ? LW'(MAX_DEPTH) : lim_ext;

  assign u_top  = wrap_idx((CW+1)'(u_old_q) + (CW+1)'(u_cnt_q) - (CW+1)'(1));
  assign r_top  = wrap_idx((CW+1)'(r_old_q) + (CW+1)'(r_cnt_q) - (CW+1)'(1));
  assign u_tail = wrap_idx((CW+1)'(u_old_q) + (CW+1)'(u_cnt_q));
  assign r_tail = wrap_idx((CW+1)'(r_old_q) + (CW+1)'(r_cnt_q));
  assign u_inc  = wrap_idx((CW+1)'(u_old_q) + (CW+1)'(1));
  assign r_inc  = wrap_idx((CW+1)'(r_old_q) + (CW+1)'(1));
  assign u_trim = (LW'(u_cnt_q) >= eff_lim) && (u_cnt_q != '0);
  assign r_trim = (LW'(r_cnt_q) >= eff_lim) && (r_cnt_q != '0);

  always_comb begin
    u_old_d = u_old_q;
    u_cnt_d = u_cnt_q;
    r_old_d = r_old_q;
    r_cnt_d = r_cnt_q;
    u_we    = 1'b0;
    r_we    = 1'b0;
    u_wdata = tag_q;
    r_wdata = u_rdata;
    ok_d    = 1'b0;
    moved_d = '0;
    unique case (op_q)
      bur_pkg::OP_PUSH: begin
        if (present_q) begin
          ok_d    = 1'b1;
          r_old_d = '0;
          r_cnt_d = '0;
          u_we    = 1'b1;
          u_wdata = tag_q;
          u_old_d = u_trim ? u_inc : u_old_q;
          u_cnt_d = u_trim ? u_cnt_q : u_cnt_q + CW'(1);
        end
      end
      bur_pkg::OP_UNDO: begin
        if (u_cnt_q != '0) begin
          ok_d    = 1'b1;
          moved_d = u_rdata;
          u_cnt_d = u_cnt_q - CW'(1);
          r_we    = 1'b1;
          r_wdata = u_rdata;
          r_old_d = r_trim ? r_inc : r_old_q;
          r_cnt_d = r_trim ? r_cnt_q : r_cnt_q + CW'(1);
        end
      end
      bur_pkg::OP_REDO: begin
        if (r_cnt_q != '0) begin
          ok_d    = 1'b1;
          moved_d = r_rdata;
          r_cnt_d = r_cnt_q - CW'(1);
          u_we    = 1'b1;
          u_wdata = r_rdata;
          u_old_d = u_trim ? u_inc : u_old_q;
          u_cnt_d = u_trim ? u_cnt_q : u_cnt_q + CW'(1);
        end
      end
      bur_pkg::OP_CLEAR: begin
        ok_d    = 1'b1;
        u_old_d = '0;
        u_cnt_d = '0;
        r_old_d = '0;
        r_cnt_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_old_q <= '0;
      u_cnt_q <= '0;
      r_old_q <= '0;
      r_cnt_q <= '0;
    end else if (cmd_i.exec) begin
      u_old_q <= u_old_d;
      u_cnt_q <= u_cnt_d;
      r_old_q <= r_old_d;
      r_cnt_q <= r_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      ok_q    <= ok_d;
      moved_q <= moved_d;
    end
  end

  bur_ring #(
    .DEPTH (MAX_DEPTH),
    .TW    (TAG_BITS)
  ) u_undo_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.exec & u_we),
    .waddr_i (u_tail),
    .wdata_i (u_wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (u_top),
    .rdata_o (u_rdata)
  );

  bur_ring #(
    .DEPTH (MAX_DEPTH),
    .TW    (TAG_BITS)
  ) u_redo_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.exec & r_we),
    .waddr_i (r_tail),
    .wdata_i (r_wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (r_top),
    .rdata_o (r_rdata)
  );

  assign ok_o            = ok_q;
  assign moved_tag_o     = moved_q;
  assign undo_avail_o    = (u_cnt_q != '0);
  assign redo_avail_o    = (r_cnt_q != '0);
  assign next_undo_tag_o = (u_cnt_q != '0) ? u_rdata : '0;
  assign next_redo_tag_o = (r_cnt_q != '0) ? r_rdata : '0;
  assign undo_depth_o    = u_cnt_q;
  assign redo_depth_o    = r_cnt_q;

endmodule

// ===== sv/bounded_undo_redo_stacks.sv =====
// Top level of the bounded undo/redo history block.
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   request | in_valid_i, in_stall_o, op/entry | in
//   result  | out_valid_o, out_stall_i, fields | out
//   config  | cfg_we_i, cfg_wdata_i            | in
//
// A request is taken only while idle; its result becomes valid after the top fetch,
// stack update and top readback states, so a new request is not taken until the
// previous result is taken. The pace is set by the registered ring read port.
// Reset empties both stacks and sets the depth limit to 16; ring contents stay.
// A stalled result holds until taken; requests stall until then.
module bounded_undo_redo_stacks #(
  parameter int MAX_DEPTH = bur_pkg::MAX_DEPTH_DEF,
  parameter int TAG_BITS  = bur_pkg::TAG_BITS_DEF,
  localparam int CW = $clog2(MAX_DEPTH + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bur_pkg::LIMIT_BITS-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     op_i,
  input  logic                           entry_present_i,
  input  logic [TAG_BITS-1:0]            entry_tag_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           ok_o,
  output logic [TAG_BITS-1:0]            moved_tag_o,
  output logic                           undo_avail_o,
  output logic                           redo_avail_o,
  output logic [TAG_BITS-1:0]            next_undo_tag_o,
  output logic [TAG_BITS-1:0]            next_redo_tag_o,
  output logic [CW-1:0]                  undo_depth_o,
  output logic [CW-1:0]                  redo_depth_o
);

  bur_pkg::cmd_t cmd;

  bur_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  bur_dp #(
    .MAX_DEPTH (MAX_DEPTH),
    .TAG_BITS  (TAG_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .op_i            (op_i),
    .entry_present_i (entry_present_i),
    .entry_tag_i     (entry_tag_i),
    .ok_o            (ok_o),
    .moved_tag_o     (moved_tag_o),
    .undo_avail_o    (undo_avail_o),
    .redo_avail_o    (redo_avail_o),
    .next_undo_tag_o (next_undo_tag_o),
    .next_redo_tag_o (next_redo_tag_o),
    .undo_depth_o    (undo_depth_o),
    .redo_depth_o    (redo_depth_o)
  );

`ifndef SYNTH
  a_undo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    undo_depth_o <= CW'(MAX_DEPTH))
    else $error("undo count above ring depth");

  a_redo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    redo_depth_o <= CW'(MAX_DEPTH))
    else $error("redo count above ring depth");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("request taken while result pending");

  a_fail_no_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ok_o) |-> (moved_tag_o == '0))
    else $error("failed request reports a moved tag");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i) |=> !out_valid_o)
    else $error("result repeated after transaction");
`endif

endmodule
